// ===== rtl/core/acvs_pkg.sv =====
// Shared types and constants for the air chamber valve sequencer.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package acvs_pkg;

    // Default sizing
    localparam int DEF_NUM_CHAMBERS = 13;
    localparam int DEF_SAMPLE_BITS  = 12;

    // Fixed field widths
    localparam int MODE_W      = 2;
    localparam int CHAMBER_W   = 4;
    localparam int SCENE_W     = 2;
    localparam int RELAYS_W    = 2;
    localparam int DIR_W       = 3;
    localparam int STEP_OUT_W  = 5;
    localparam int THR_W       = 12;

    // Configuration port
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 1'b1;

    localparam logic [THR_W-1:0] LOW_THR_RESET  = 12'd1400;
    localparam logic [THR_W-1:0] HIGH_THR_RESET = 12'd3900;

    // Item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_START  = 2'd2
    } mode_t;

    // Scene codes
    localparam logic [SCENE_W-1:0] SCENE_NONE    = 2'd0;
    localparam logic [SCENE_W-1:0] SCENE_DEFLATE = 2'd1;
    localparam logic [SCENE_W-1:0] SCENE_INFLATE = 2'd2;
    localparam logic [SCENE_W-1:0] SCENE_WAVE    = 2'd3;

    // Relay patterns
    localparam logic [RELAYS_W-1:0] RELAYS_OFF  = 2'b00;
    localparam logic [RELAYS_W-1:0] RELAYS_ON   = 2'b11;
    localparam logic [DIR_W-1:0]    DIR_OFF     = 3'b000;
    localparam logic [DIR_W-1:0]    DIR_DEFLATE = 3'b011;
    localparam logic [DIR_W-1:0]    DIR_INFLATE = 3'b101;

    // Scene control state
    typedef struct packed {
        logic [SCENE_W-1:0]  scene;
        logic                running;
        logic                pump;
        logic [RELAYS_W-1:0] relays;
        logic [DIR_W-1:0]    dir;
    } ctl_t;

endpackage

// ===== rtl/core/acvs_ifs.sv =====
// Valid/ready channel interfaces for the valve sequencer input and result beats.
// Depends on acvs_pkg.
`timescale 1ns / 1ps

interface acvs_in_if
    import acvs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [CHAMBER_W-1:0]   chamber;
    logic [SAMPLE_BITS-1:0] pressure;
    logic [SCENE_W-1:0]     scene;

    modport source (output valid, mode, chamber, pressure, scene, input ready);
    modport sink   (input valid, mode, chamber, pressure, scene, output ready);
endinterface

interface acvs_out_if
    import acvs_pkg::*;
#(
    parameter int NUM_CHAMBERS = DEF_NUM_CHAMBERS
) ();
    logic                    valid;
    logic                    ready;
    logic                    pump_on;
    logic [RELAYS_W-1:0]     inflate_relays;
    logic [DIR_W-1:0]        direction_valves;
    logic [NUM_CHAMBERS-1:0] inflate_valve_mask;
    logic [NUM_CHAMBERS-1:0] deflate_valve_mask;
    logic [STEP_OUT_W-1:0]   step_index;
    logic                    running;
    logic                    scene_done;

    modport source (output valid, pump_on, inflate_relays, direction_valves,
                    inflate_valve_mask, deflate_valve_mask, step_index, running,
                    scene_done, input ready);
    modport sink   (input valid, pump_on, inflate_relays, direction_valves,
                    inflate_valve_mask, deflate_valve_mask, step_index, running,
                    scene_done, output ready);
endinterface

// ===== rtl/core/air_chamber_valve_sequencer.sv =====
// Air chamber valve sequencer: top level with beat registers, state and APB registers.
// Depends on acvs_pkg, acvs_ifs (acvs_in_if, acvs_out_if) and acvs_step.
//
// Usage:
//   in_ch carries one beat per item: a pressure sample for one chamber, a tick
//   that advances the running scene, or a start that selects a scene.
//   out_ch carries exactly one result beat per item: the relay and valve state
//   after that item, the scene step, the running flag and a scene_done pulse.
//   The APB port sets low_threshold (0x0) and high_threshold (0x4); write them
//   only while no item is in flight.
// Path: an accepted beat is captured in the input register, worked through the
//   compare and step logic, and captured in the result register that drives out_ch.
// Throughput: one item per cycle while out_ch.ready is high; the step logic sits
//   between the input register and the result register.
// Reset: clears the pressure table, ends any scene, turns all relays and valves
//   off and restores both thresholds; no clearing pass is needed.
// Stall: while out_ch.ready is low the result holds; one more beat is taken into
//   the input register, after which in_ch.ready drops until the result is taken.
`timescale 1ns / 1ps

module air_chamber_valve_sequencer
    import acvs_pkg::*;
#(
    parameter int NUM_CHAMBERS = DEF_NUM_CHAMBERS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    acvs_in_if.sink             in_ch,
    acvs_out_if.source          out_ch
);

    localparam int STEP_W   = $clog2(2 * NUM_CHAMBERS + 3);
    localparam int CH_IDX_W = (NUM_CHAMBERS > 1) ? $clog2(NUM_CHAMBERS) : 1;

    // Configuration registers
    logic [THR_W-1:0]     low_thr_reg;
    logic [THR_W-1:0]     high_thr_reg;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Input beat register
    logic                   in_vld_reg;
    logic [MODE_W-1:0]      in_mode_reg;
    logic [CHAMBER_W-1:0]   in_chamber_reg;
    logic [SAMPLE_BITS-1:0] in_pressure_reg;
    logic [SCENE_W-1:0]     in_scene_reg;
    logic                   in_vld_next;
    logic                   advance;

    // Block state
    ctl_t                                     ctl_reg;
    ctl_t                                     ctl_next;
    logic [STEP_W-1:0]                        step_reg;
    logic [STEP_W-1:0]                        step_next;
    logic [NUM_CHAMBERS-1:0]                  inflate_reg;
    logic [NUM_CHAMBERS-1:0]                  inflate_next;
    logic [NUM_CHAMBERS-1:0]                  deflate_reg;
    logic [NUM_CHAMBERS-1:0]                  deflate_next;
    logic [NUM_CHAMBERS-1:0][SAMPLE_BITS-1:0] pt_reg;
    logic                                     done_next;
    logic                                     sample_we;

    // Result register
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic                    out_pump_reg;
    logic [RELAYS_W-1:0]     out_relays_reg;
    logic [DIR_W-1:0]        out_dir_reg;
    logic [NUM_CHAMBERS-1:0] out_inflate_reg;
    logic [NUM_CHAMBERS-1:0] out_deflate_reg;
    logic [STEP_OUT_W-1:0]   out_step_reg;
    logic                    out_running_reg;
    logic                    out_done_reg;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1 -: REG_IDX_W];

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_LOW_THR:  prdata = PDATA_W'(low_thr_reg);
            REG_HIGH_THR: prdata = PDATA_W'(high_thr_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THR_RESET;
            high_thr_reg <= HIGH_THR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_LOW_THR)
                low_thr_reg <= pwdata[THR_W-1:0];
            if (cfg_idx == REG_HIGH_THR)
                high_thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ---------------- beat flow ----------------
    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ch.valid && in_ch.ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (out_ch.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_mode_reg     <= in_ch.mode;
            in_chamber_reg  <= in_ch.chamber;
            in_pressure_reg <= in_ch.pressure;
            in_scene_reg    <= in_ch.scene;
        end
    end

    // ---------------- step logic ----------------
    acvs_step #(
        .NUM_CHAMBERS (NUM_CHAMBERS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .STEP_W       (STEP_W)
    ) u_step (
        .mode         (in_mode_reg),
        .scene        (in_scene_reg),
        .ctl          (ctl_reg),
        .step         (step_reg),
        .inflate      (inflate_reg),
        .deflate      (deflate_reg),
        .pressures    (pt_reg),
        .low_thr      (low_thr_reg),
        .high_thr     (high_thr_reg),
        .ctl_next     (ctl_next),
        .step_next    (step_next),
        .inflate_next (inflate_next),
        .deflate_next (deflate_next),
        .done         (done_next)
    );

    // samples for chambers past the last one are dropped
    assign sample_we = advance && (in_mode_reg == MODE_SAMPLE)
                       && ({1'b0, in_chamber_reg} < (CHAMBER_W + 1)'(NUM_CHAMBERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '0;
            step_reg    <= '0;
            inflate_reg <= '0;
            deflate_reg <= '0;
            pt_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                ctl_reg     <= ctl_next;
                step_reg    <= step_next;
                inflate_reg <= inflate_next;
                deflate_reg <= deflate_next;
            end
            if (sample_we)
                pt_reg[in_chamber_reg[CH_IDX_W-1:0]] <= in_pressure_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pump_reg    <= ctl_next.pump;
            out_relays_reg  <= ctl_next.relays;
            out_dir_reg     <= ctl_next.dir;
            out_inflate_reg <= inflate_next;
            out_deflate_reg <= deflate_next;
            out_step_reg    <= STEP_OUT_W'(step_next);
            out_running_reg <= ctl_next.running;
            out_done_reg    <= done_next;
        end
    end

    assign out_ch.valid              = out_vld_reg;
    assign out_ch.pump_on            = out_pump_reg;
    assign out_ch.inflate_relays     = out_relays_reg;
    assign out_ch.direction_valves   = out_dir_reg;
    assign out_ch.inflate_valve_mask = out_inflate_reg;
    assign out_ch.deflate_valve_mask = out_deflate_reg;
    assign out_ch.step_index         = out_step_reg;
    assign out_ch.running            = out_running_reg;
    assign out_ch.scene_done         = out_done_reg;

endmodule

// ===== rtl/core/acvs_step.sv =====
// Next-state logic for one item: threshold compares and scene step update.
// Depends on acvs_pkg.
`timescale 1ns / 1ps

module acvs_step
    import acvs_pkg::*;
#(
    parameter int NUM_CHAMBERS = DEF_NUM_CHAMBERS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int STEP_W       = $clog2(2 * NUM_CHAMBERS + 3)
) (
    input  logic [MODE_W-1:0]                           mode,
    input  logic [SCENE_W-1:0]                          scene,
    input  ctl_t                                        ctl,
    input  logic [STEP_W-1:0]                           step,
    input  logic [NUM_CHAMBERS-1:0]                     inflate,
    input  logic [NUM_CHAMBERS-1:0]                     deflate,
    input  logic [NUM_CHAMBERS-1:0][SAMPLE_BITS-1:0]    pressures,
    input  logic [THR_W-1:0]                            low_thr,
    input  logic [THR_W-1:0]                            high_thr,
    output ctl_t                                        ctl_next,
    output logic [STEP_W-1:0]                           step_next,
    output logic [NUM_CHAMBERS-1:0]                     inflate_next,
    output logic [NUM_CHAMBERS-1:0]                     deflate_next,
    output logic                                        done
);

    localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int CH_IDX_W = (NUM_CHAMBERS > 1) ? $clog2(NUM_CHAMBERS) : 1;

    localparam logic [STEP_W-1:0] S_ZERO       = '0;
    localparam logic [STEP_W-1:0] S_ONE        = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_TWO        = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_LAST_FILL  = STEP_W'(NUM_CHAMBERS);
    localparam logic [STEP_W-1:0] S_REFILL     = STEP_W'(NUM_CHAMBERS + 1);
    localparam logic [STEP_W-1:0] S_DRAIN0     = STEP_W'(NUM_CHAMBERS + 2);
    localparam logic [STEP_W-1:0] S_LAST_DRAIN = STEP_W'(2 * NUM_CHAMBERS + 1);
    localparam logic [STEP_W-1:0] TOP_STEP     = STEP_W'(NUM_CHAMBERS - 1);

    logic [NUM_CHAMBERS-1:0] fill_vec;
    logic [NUM_CHAMBERS-1:0] drain_vec;
    logic                    wave_fill;
    logic [STEP_W-1:0]       wave_pos;
    logic [CH_IDX_W-1:0]     wave_c;
    logic                    wave_want;
    logic [STEP_W-1:0]       wave_base;
    logic                    is_fill_scene;

    // One compare pair per chamber
    always_comb
    begin
        for (int i = 0; i < NUM_CHAMBERS; i++)
        begin
            fill_vec[i]  = CMP_W'(pressures[i]) < CMP_W'(high_thr);
            drain_vec[i] = CMP_W'(pressures[i]) > CMP_W'(low_thr);
        end
    end

    // Wave chamber: top first on the fill pass, top last on the drain pass
    always_comb
    begin
        wave_fill = (step <= S_LAST_FILL);
        if (wave_fill)
            wave_pos = (step == S_ONE) ? TOP_STEP : step - S_TWO;
        else
            wave_pos = (step == S_REFILL) ? S_ZERO : step - S_DRAIN0;
        wave_c    = wave_pos[CH_IDX_W-1:0];
        wave_want = wave_fill ? fill_vec[wave_c] : drain_vec[wave_c];
        wave_base = (step == S_REFILL) ? S_DRAIN0 : step;
    end

    assign is_fill_scene = (ctl.scene == SCENE_INFLATE);

    always_comb
    begin
        ctl_next     = ctl;
        step_next    = step;
        inflate_next = inflate;
        deflate_next = deflate;
        done         = 1'b0;
        case (mode)
            MODE_TICK:
            begin
                if (ctl.running)
                begin
                    case (ctl.scene)
                        SCENE_DEFLATE, SCENE_INFLATE:
                        begin
                            if (step == S_ZERO)
                            begin
                                ctl_next.pump   = 1'b1;
                                ctl_next.relays = RELAYS_ON;
                                ctl_next.dir    = is_fill_scene ? DIR_INFLATE : DIR_DEFLATE;
                                step_next       = S_ONE;
                            end
                            else if (step == S_ONE)
                            begin
                                if (is_fill_scene)
                                begin
                                    inflate_next = fill_vec;
                                    if (fill_vec == '0)
                                        step_next = S_TWO;
                                end
                                else
                                begin
                                    deflate_next = drain_vec;
                                    if (drain_vec == '0)
                                        step_next = S_TWO;
                                end
                            end
                            else
                            begin
                                ctl_next.pump    = 1'b0;
                                ctl_next.relays  = RELAYS_OFF;
                                ctl_next.dir     = DIR_OFF;
                                ctl_next.scene   = SCENE_NONE;
                                ctl_next.running = 1'b0;
                                step_next        = S_ZERO;
                                done             = 1'b1;
                            end
                        end
                        SCENE_WAVE:
                        begin
                            if (step == S_ZERO)
                            begin
                                ctl_next.pump   = 1'b1;
                                ctl_next.relays = RELAYS_ON;
                                ctl_next.dir    = DIR_INFLATE;
                                step_next       = S_ONE;
                            end
                            else if (step <= S_LAST_DRAIN)
                            begin
                                // refill step re-drives the relays and runs the first drain step
                                if (step == S_REFILL)
                                begin
                                    ctl_next.pump   = 1'b1;
                                    ctl_next.relays = RELAYS_ON;
                                    ctl_next.dir    = DIR_INFLATE;
                                end
                                if (wave_fill)
                                    inflate_next[wave_c] = wave_want;
                                else
                                    deflate_next[wave_c] = wave_want;
                                step_next = wave_base + {{(STEP_W-1){1'b0}}, ~wave_want};
                            end
                            else
                            begin
                                ctl_next.pump    = 1'b0;
                                ctl_next.relays  = RELAYS_OFF;
                                ctl_next.dir     = DIR_OFF;
                                ctl_next.scene   = SCENE_NONE;
                                ctl_next.running = 1'b0;
                                step_next        = S_ZERO;
                                done             = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            MODE_START:
            begin
                if (scene != SCENE_NONE)
                begin
                    ctl_next.scene   = scene;
                    ctl_next.running = 1'b1;
                    step_next        = S_ZERO;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/acvs_checker.sv =====
// Port-level checks on the valve sequencer result channel, bound to the top level.
// Depends on acvs_pkg and air_chamber_valve_sequencer.
`timescale 1ns / 1ps

module acvs_checker
    import acvs_pkg::*;
#(
    parameter int NUM_CHAMBERS = DEF_NUM_CHAMBERS
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    pump_on,
    input logic [RELAYS_W-1:0]     inflate_relays,
    input logic [DIR_W-1:0]        direction_valves,
    input logic [NUM_CHAMBERS-1:0] inflate_valve_mask,
    input logic [NUM_CHAMBERS-1:0] deflate_valve_mask,
    input logic [STEP_OUT_W-1:0]   step_index,
    input logic                    running,
    input logic                    scene_done
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(inflate_valve_mask) && $stable(deflate_valve_mask)
            && $stable(step_index) && $stable(pump_on))
        else $error("result beat changed while stalled");

    // no scene: pump, relays and direction valves are off and the step is zero
    a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> !pump_on && step_index == '0
            && inflate_relays == RELAYS_OFF && direction_valves == DIR_OFF)
        else $error("relays active without a running scene");

    // pump on implies the inflate relays on and a legal direction
    a_pump_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pump_on |-> inflate_relays == RELAYS_ON
            && (direction_valves == DIR_DEFLATE || direction_valves == DIR_INFLATE))
        else $error("pump on with inconsistent relays");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scene_done |-> !running)
        else $error("scene_done while still running");

endmodule

bind air_chamber_valve_sequencer acvs_checker #(
    .NUM_CHAMBERS (NUM_CHAMBERS)
) u_acvs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .pump_on            (out_ch.pump_on),
    .inflate_relays     (out_ch.inflate_relays),
    .direction_valves   (out_ch.direction_valves),
    .inflate_valve_mask (out_ch.inflate_valve_mask),
    .deflate_valve_mask (out_ch.deflate_valve_mask),
    .step_index         (out_ch.step_index),
    .running            (out_ch.running),
    .scene_done         (out_ch.scene_done)
);

// ===== verif/acvs_relay_checker.sv =====
// Checker for the air chamber valve sequencer: watches both channels and the APB
// writes, predicts every result beat and compares it. Depends on acvs_pkg and acvs_ifs.
`timescale 1ns / 1ps

module acvs_relay_checker
    import acvs_pkg::*;
#(
    parameter int NUM_CHAMBERS = DEF_NUM_CHAMBERS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    acvs_in_if                 in_ch,
    acvs_out_if                out_ch,
    output int                 relay_errors,
    output int                 results_owed
);

    localparam int TOP_CHAMBER = NUM_CHAMBERS - 1;

    typedef struct packed {
        logic                    pump_on;
        logic [RELAYS_W-1:0]     inflate_relays;
        logic [DIR_W-1:0]        direction_valves;
        logic [NUM_CHAMBERS-1:0] inflate_valve_mask;
        logic [NUM_CHAMBERS-1:0] deflate_valve_mask;
        logic [STEP_OUT_W-1:0]   step_index;
        logic                    running;
        logic                    scene_done;
    } relay_result_t;

    // predicted block state
    logic [THR_W-1:0]        thr_low;
    logic [THR_W-1:0]        thr_high;
    logic [SAMPLE_BITS-1:0]  press_tab [NUM_CHAMBERS];
    logic [SCENE_W-1:0]      scene_sel;
    int                      step_no;
    logic                    scene_live;
    logic                    pump_q;
    logic [RELAYS_W-1:0]     relays_q;
    logic [DIR_W-1:0]        dir_q;
    logic [NUM_CHAMBERS-1:0] infl_mask;
    logic [NUM_CHAMBERS-1:0] defl_mask;

    relay_result_t relay_expect_q[$];
    relay_result_t head;
    int            errs = 0;
    int            owed = 0;

    wire [REG_IDX_W-1:0] apb_reg = paddr[2 +: REG_IDX_W];

    assign relay_errors = errs;
    assign results_owed = owed;

    function automatic void power_up(input logic [DIR_W-1:0] dir);
        pump_q   = 1'b1;
        relays_q = RELAYS_ON;
        dir_q    = dir;
    endfunction

    function automatic void shut_off();
        pump_q     = 1'b0;
        relays_q   = RELAYS_OFF;
        dir_q      = DIR_OFF;
        scene_sel  = SCENE_NONE;
        step_no    = 0;
        scene_live = 1'b0;
    endfunction

    // one wave step: hold the valve open until the chamber reaches its target
    function automatic void settle_chamber(input int c, input bit fill);
        logic want;
        want = fill ? (press_tab[c] < thr_high) : (press_tab[c] > thr_low);
        if (fill)
            infl_mask[c] = want;
        else
            defl_mask[c] = want;
        if (!want)
            step_no++;
    endfunction

    function automatic bit advance_scene();
        logic [NUM_CHAMBERS-1:0] want;
        bit                      fill;
        if (scene_sel == SCENE_DEFLATE || scene_sel == SCENE_INFLATE)
        begin
            fill = (scene_sel == SCENE_INFLATE);
            if (step_no == 0)
            begin
                power_up(fill ? DIR_INFLATE : DIR_DEFLATE);
                step_no = 1;
            end
            else if (step_no == 1)
            begin
                for (int c = 0; c < NUM_CHAMBERS; c++)
                    want[c] = fill ? (press_tab[c] < thr_high) : (press_tab[c] > thr_low);
                if (fill)
                    infl_mask = want;
                else
                    defl_mask = want;
                if (want == '0)
                    step_no = 2;
            end
            else
            begin
                shut_off();
                return 1'b1;
            end
            return 1'b0;
        end
        if (scene_sel == SCENE_WAVE)
        begin
            if (step_no == 0)
            begin
                power_up(DIR_INFLATE);
                step_no = 1;
            end
            else if (step_no == 1)
                settle_chamber(TOP_CHAMBER, 1'b1);
            else if (step_no <= NUM_CHAMBERS)
                settle_chamber(step_no - 2, 1'b1);
            else if (step_no == NUM_CHAMBERS + 1)
            begin
                // turnaround step runs straight into the first deflate step
                power_up(DIR_INFLATE);
                step_no = NUM_CHAMBERS + 2;
                settle_chamber(0, 1'b0);
            end
            else if (step_no <= 2 * NUM_CHAMBERS)
                settle_chamber(step_no - (NUM_CHAMBERS + 2), 1'b0);
            else if (step_no == 2 * NUM_CHAMBERS + 1)
                settle_chamber(TOP_CHAMBER, 1'b0);
            else
            begin
                shut_off();
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic relay_result_t predict_relays(
        input logic [MODE_W-1:0]      mode,
        input logic [CHAMBER_W-1:0]   chamber,
        input logic [SAMPLE_BITS-1:0] pressure,
        input logic [SCENE_W-1:0]     scene
    );
        relay_result_t r;
        bit            done;
        done = 1'b0;
        case (mode)
            MODE_SAMPLE:
                if (chamber < NUM_CHAMBERS)
                    press_tab[chamber] = pressure;
            MODE_TICK:
                if (scene_live)
                    done = advance_scene();
            MODE_START:
                if (scene != SCENE_NONE)
                begin
                    scene_sel  = scene;
                    step_no    = 0;
                    scene_live = 1'b1;
                end
            default: ;
        endcase
        r.pump_on            = pump_q;
        r.inflate_relays     = relays_q;
        r.direction_valves   = dir_q;
        r.inflate_valve_mask = infl_mask;
        r.deflate_valve_mask = defl_mask;
        r.step_index         = STEP_OUT_W'(step_no);
        r.running            = scene_live;
        r.scene_done         = done;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low    = LOW_THR_RESET;
            thr_high   = HIGH_THR_RESET;
            for (int c = 0; c < NUM_CHAMBERS; c++)
                press_tab[c] = '0;
            scene_sel  = SCENE_NONE;
            step_no    = 0;
            scene_live = 1'b0;
            pump_q     = 1'b0;
            relays_q   = RELAYS_OFF;
            dir_q      = DIR_OFF;
            infl_mask  = '0;
            defl_mask  = '0;
            relay_expect_q.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (relay_expect_q.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    errs++;
                end
                else
                begin
                    head = relay_expect_q.pop_front();
                    check_field("pump_on", 32'(head.pump_on), 32'(out_ch.pump_on));
                    check_field("inflate_relays", 32'(head.inflate_relays),
                                32'(out_ch.inflate_relays));
                    check_field("direction_valves", 32'(head.direction_valves),
                                32'(out_ch.direction_valves));
                    check_field("inflate_valve_mask", 32'(head.inflate_valve_mask),
                                32'(out_ch.inflate_valve_mask));
                    check_field("deflate_valve_mask", 32'(head.deflate_valve_mask),
                                32'(out_ch.deflate_valve_mask));
                    check_field("step_index", 32'(head.step_index),
                                32'(out_ch.step_index));
                    check_field("running", 32'(head.running), 32'(out_ch.running));
                    check_field("scene_done", 32'(head.scene_done),
                                32'(out_ch.scene_done));
                end
            end
            if (in_ch.valid && in_ch.ready)
                relay_expect_q.push_back(predict_relays(in_ch.mode, in_ch.chamber,
                                                        in_ch.pressure, in_ch.scene));
            if (psel && penable && pwrite && pready)
            begin
                if (apb_reg == REG_LOW_THR)
                    thr_low = pwdata[THR_W-1:0];
                else if (apb_reg == REG_HIGH_THR)
                    thr_high = pwdata[THR_W-1:0];
            end
        end
        owed = relay_expect_q.size();
    end

endmodule

// ===== verif/air_chamber_valve_sequencer_tb.sv =====
// Testbench top for the air chamber valve sequencer: clock, reset, APB setup,
// input beats and result-side stalls; verdict from acvs_relay_checker.
// Depends on acvs_pkg, acvs_ifs, air_chamber_valve_sequencer and acvs_relay_checker.
`timescale 1ns / 1ps

module air_chamber_valve_sequencer_tb;
    import acvs_pkg::*;

    localparam int NCH         = DEF_NUM_CHAMBERS;
    localparam int TOP_CHAMBER = NCH - 1;
    localparam int CHAMBER_MAX = (1 << CHAMBER_W) - 1;
    localparam int PRESS_MAX   = (1 << DEF_SAMPLE_BITS) - 1;
    localparam int PHASE_ITEMS = 141;
    localparam int FULL_RUN    = 99;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    acvs_in_if  in_ch ();
    acvs_out_if out_ch ();

    int relay_errors;
    int results_owed;

    logic [THR_W-1:0] cfg_low  = LOW_THR_RESET;
    logic [THR_W-1:0] cfg_high = HIGH_THR_RESET;
    int               burst_left = 0;
    int               items_sent = 0;

    int sink_cnt   = 0;
    int sink_style = 0;
    int sink_hold  = 0;

    air_chamber_valve_sequencer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    acvs_relay_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .relay_errors (relay_errors),
        .results_owed (results_owed)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side: one of four stall styles is picked at random; style 0 never stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            sink_cnt++;
            if (sink_cnt % 97 == 0)
                sink_style = $urandom_range(0, 3);
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (sink_style)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ((sink_cnt % 5) < 3);
                    default:
                    begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            sink_hold = $urandom_range(1, 20);
                    end
                endcase
            end
        end
    end

    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [CHAMBER_W-1:0] c,
                             input logic [DEF_SAMPLE_BITS-1:0] p,
                             input logic [SCENE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= m;
        in_ch.chamber  <= c;
        in_ch.pressure <= p;
        in_ch.scene    <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic sample(input logic [CHAMBER_W-1:0] c, input logic [DEF_SAMPLE_BITS-1:0] p);
        send_beat(MODE_SAMPLE, c, p, SCENE_W'($urandom_range(0, 3)));
    endtask

    task automatic tick();
        send_beat(MODE_TICK, CHAMBER_W'($urandom_range(0, CHAMBER_MAX)),
                  DEF_SAMPLE_BITS'($urandom_range(0, PRESS_MAX)),
                  SCENE_W'($urandom_range(0, 3)));
    endtask

    task automatic start_scene(input logic [SCENE_W-1:0] s);
        send_beat(MODE_START, CHAMBER_W'($urandom_range(0, CHAMBER_MAX)),
                  DEF_SAMPLE_BITS'($urandom_range(0, PRESS_MAX)), s);
    endtask

    task automatic noise_item();
        send_beat(MODE_W'($urandom_range(0, 3)), CHAMBER_W'($urandom_range(0, CHAMBER_MAX)),
                  DEF_SAMPLE_BITS'($urandom_range(0, PRESS_MAX)),
                  SCENE_W'($urandom_range(0, 3)));
    endtask

    // pressure that counts as reached for an inflate or a deflate target
    function automatic logic [DEF_SAMPLE_BITS-1:0] target_level(input bit fill);
        return fill ? DEF_SAMPLE_BITS'($urandom_range(cfg_high, PRESS_MAX))
                    : DEF_SAMPLE_BITS'($urandom_range(0, cfg_low));
    endfunction

    // drains the result side with the input channel idle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LOW_THR)
            cfg_low = val;
        else
            cfg_high = val;
    endtask

    // a scene run that is fed the samples it waits for; cut_at aborts it early
    task automatic run_scene(input logic [SCENE_W-1:0] sc, input int cut_at);
        int order [NCH];
        int j;
        int c;
        int swap;
        bit fill;
        start_scene(sc);
        tick();
        if (sc == SCENE_WAVE)
        begin
            for (int k = 0; k < 2 * NCH; k++)
            begin
                if (k == cut_at)
                    return;
                if (k == 0 || k == 2 * NCH - 1)
                    c = TOP_CHAMBER;
                else if (k < NCH)
                    c = k - 1;
                else
                    c = k - NCH;
                if ($urandom_range(0, 3) == 0)
                begin
                    sample(CHAMBER_W'(c), DEF_SAMPLE_BITS'($urandom_range(0, PRESS_MAX)));
                    tick();
                end
                sample(CHAMBER_W'(c), target_level(k < NCH));
                tick();
            end
        end
        else
        begin
            fill = (sc == SCENE_INFLATE);
            for (int k = 0; k < NCH; k++)
                order[k] = k;
            for (int k = NCH - 1; k > 0; k--)
            begin
                j        = $urandom_range(0, k);
                swap     = order[k];
                order[k] = order[j];
                order[j] = swap;
            end
            for (int k = 0; k < NCH; k++)
            begin
                if (k == cut_at)
                    return;
                if ($urandom_range(0, 2) == 0)
                begin
                    sample(CHAMBER_W'(order[k]),
                           DEF_SAMPLE_BITS'($urandom_range(0, PRESS_MAX)));
                    tick();
                end
                sample(CHAMBER_W'(order[k]), target_level(fill));
                if ($urandom_range(0, 3) == 0)
                    tick();
            end
            tick();
        end
        tick();
        if ($urandom_range(0, 3) == 0)
            tick();
    endtask

    initial
    begin
        int pick;
        int phase_end;
        int guard;
        logic [SCENE_W-1:0] sc;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_SAMPLE;
        in_ch.chamber  = '0;
        in_ch.pressure = '0;
        in_ch.scene    = SCENE_NONE;
        out_ch.ready   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, ignored items, restarts, the start of a wave scene
        sample('0, '0);
        sample(CHAMBER_W'(TOP_CHAMBER), DEF_SAMPLE_BITS'(PRESS_MAX));
        sample(CHAMBER_W'(CHAMBER_MAX), DEF_SAMPLE_BITS'(PRESS_MAX));
        sample(CHAMBER_W'(NCH), 12'h5A5);
        send_beat(MODE_UNUSED, 4'd5, 12'h555, SCENE_WAVE);
        tick();
        start_scene(SCENE_NONE);
        start_scene(SCENE_DEFLATE);
        tick();
        tick();
        sample(CHAMBER_W'(TOP_CHAMBER), '0);
        tick();
        start_scene(SCENE_INFLATE);
        tick();
        tick();
        start_scene(SCENE_WAVE);
        tick();
        sample(CHAMBER_W'(TOP_CHAMBER), DEF_SAMPLE_BITS'(PRESS_MAX));
        tick();
        tick();
        sample('0, DEF_SAMPLE_BITS'(PRESS_MAX));
        tick();
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph != 0)
            begin
                wait_idle();
                case (ph)
                    1:
                    begin
                        apb_write(REG_LOW_THR, '0);
                        apb_write(REG_HIGH_THR, '1);
                    end
                    2:
                    begin
                        apb_write(REG_LOW_THR, '1);
                        apb_write(REG_HIGH_THR, '0);
                    end
                    3:
                    begin
                        apb_write(REG_LOW_THR, THR_W'($urandom_range(0, 4095)));
                        apb_write(REG_HIGH_THR, THR_W'($urandom_range(0, 4095)));
                    end
                    default:
                    begin
                        apb_write(REG_LOW_THR, LOW_THR_RESET);
                        apb_write(REG_HIGH_THR, HIGH_THR_RESET);
                    end
                endcase
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                sc   = SCENE_W'($urandom_range(1, 3));
                if (pick < 8)
                    run_scene(sc, FULL_RUN);
                else if (pick == 8)
                    run_scene(sc, $urandom_range(0, 2 * NCH - 1));
                else
                    repeat ($urandom_range(1, 8)) noise_item();
            end
        end

        in_ch.valid <= 1'b0;
        guard = 0;
        @(negedge clk);
        while (results_owed != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (relay_errors == 0 && results_owed == 0)
            $display("air_chamber_valve_sequencer regression: pass");
        else
            $display("air_chamber_valve_sequencer regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("air_chamber_valve_sequencer regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/acvs_pkg.sv
rtl/core/acvs_ifs.sv
rtl/core/acvs_step.sv
rtl/core/air_chamber_valve_sequencer.sv
rtl/core/acvs_checker.sv
verif/acvs_relay_checker.sv
verif/air_chamber_valve_sequencer_tb.sv
